// ----- hw/rtl/coe_pkg.sv -----
// -----------------------------------------------------------------------------
// coe_pkg
// Shared types and constants for the clock offset minimum estimator.
// -----------------------------------------------------------------------------
package coe_pkg;

	// request codes carried in req_type
	typedef enum logic {
		REQ_OBSERVE = 1'b0,
		REQ_CONVERT = 1'b1
	} coe_req_t;

	// largest device time (us) whose ns value fits in a signed 64-bit word
	localparam logic [63:0] DEV_US_MAX     = 64'd9223372036854775;
	localparam logic [15:0] SAMPLES_RESET  = 16'd10;
	localparam logic [15:0] COUNT_MAX      = 16'hFFFF;

	typedef struct packed {
		logic        locked;
		logic [15:0] sample_count;
		logic        have_candidate;
		logic [63:0] min_candidate;
		logic [63:0] locked_offset;
		logic [63:0] last_host_time;
		logic [63:0] last_device_time;
		logic        have_last_device;
	} coe_state_t;

	localparam coe_state_t STATE_RESET = '{default: '0};

	typedef struct packed {
		logic        synced;
		logic [63:0] host_equiv_ns;
		logic        convert_ok;
	} coe_result_t;

endpackage

// ----- hw/rtl/coe_conv.sv -----
// -----------------------------------------------------------------------------
// coe_conv
// Device microseconds to nanoseconds, with range check against int64.
// -----------------------------------------------------------------------------
module coe_conv import coe_pkg::*; (
	input  logic [63:0] device_us,
	output logic [63:0] device_ns,
	output logic        too_large
);

	// x * 1000 = x * 1024 - x * 16 - x * 8
	assign device_ns = (device_us << 10) - (device_us << 4) - (device_us << 3);
	assign too_large = (device_us > DEV_US_MAX);

endmodule

// ----- hw/rtl/coe_update.sv -----
// -----------------------------------------------------------------------------
// coe_update
// Next-state and result logic for one observe or convert beat.
// -----------------------------------------------------------------------------
module coe_update import coe_pkg::*; (
	input  coe_state_t  cur,
	input  logic [15:0] samples_needed,
	input  logic        req_type,
	input  logic [63:0] device_us,
	input  logic [63:0] host_ns,
	input  logic [63:0] device_ns,
	input  logic        too_large,
	output coe_state_t  nxt,
	output coe_result_t res
);

	logic        host_valid;
	logic        host_back;
	logic        dev_back;
	logic [63:0] cand;
	logic [63:0] sum;
	logic        sum_ovf;
	logic [15:0] cnt_inc;
	coe_state_t  eff;

	assign host_valid = !host_ns[63] && (host_ns != 64'd0);
	assign host_back  = (cur.locked || (cur.sample_count != 16'd0)) &&
		($signed(host_ns) < $signed(cur.last_host_time));
	assign dev_back   = cur.have_last_device && (device_us < cur.last_device_time);
	// host > 0 and ns >= 0, so no wrap here
	assign cand       = host_ns - device_ns;
	assign sum        = device_ns + cur.locked_offset;
	// ns >= 0: only a positive offset can push the sum past int64 max
	assign sum_ovf    = !cur.locked_offset[63] && sum[63];

	always_comb begin
		nxt     = cur;
		res     = '0;
		eff     = (host_back || dev_back) ? STATE_RESET : cur;
		cnt_inc = (eff.sample_count != COUNT_MAX) ? eff.sample_count + 16'd1
			: eff.sample_count;
		if (req_type == REQ_OBSERVE) begin
			if (host_valid) begin
				if (too_large) begin
					nxt = STATE_RESET;
				end else begin
					nxt = eff;
					if (!eff.locked) begin
						if (!eff.have_candidate ||
							($signed(cand) < $signed(eff.min_candidate))) begin
							nxt.min_candidate  = cand;
							nxt.have_candidate = 1'b1;
						end
						nxt.sample_count = cnt_inc;
						// a zero setting locks at once, same as one
						if (cnt_inc >= samples_needed) begin
							nxt.locked_offset = nxt.min_candidate;
							nxt.locked        = 1'b1;
						end
					end
					nxt.last_host_time   = host_ns;
					nxt.last_device_time = device_us;
					nxt.have_last_device = 1'b1;
					res.synced           = nxt.locked;
				end
			end
		end else begin
			if (cur.locked) begin
				res.synced = 1'b1;
				if (!too_large && !sum_ovf) begin
					res.host_equiv_ns = sum;
					res.convert_ok    = 1'b1;
				end
			end
		end
	end

endmodule

// ----- hw/rtl/clock_offset_min_estimator.sv -----
// -----------------------------------------------------------------------------
// clock_offset_min_estimator
// Minimum-delay offset estimate between a device us clock and a host ns clock.
//
// Takes one item per clock cycle while in_stall is low, observe or convert,
// and returns one result per item: the item waits in the input register,
// then the estimator state is updated and the result register loaded. The
// state update is combinational from the input register, so items in a row
// see each other's effect with no bubble. A result waiting under out_stall
// holds one item in the input register before in_stall rises. A write on the
// cfg channel sets samples_needed and clears the estimate; cfg_ready is
// always high and writes are expected only while the block is idle.
// -----------------------------------------------------------------------------
module clock_offset_min_estimator import coe_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [0:0]  req_type,
	input  logic [63:0] device_time_us,
	input  logic signed [63:0] host_time_ns,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [0:0]  synced,
	output logic signed [63:0] host_equiv_ns,
	output logic [0:0]  convert_ok
);

	logic        valid_s1;
	logic        req_type_s1;
	logic [63:0] dev_s1;
	logic [63:0] host_s1;

	logic        out_valid_q;
	coe_result_t res_q;

	coe_state_t  state_q;
	logic [15:0] samples_needed_q;

	logic        accept;
	logic        advance;
	logic [63:0] dev_ns;
	logic        too_large;
	coe_state_t  state_nxt;
	coe_result_t res_nxt;

	assign advance   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign accept    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_type_s1 <= req_type[0];
			dev_s1      <= device_time_us;
			host_s1     <= host_time_ns;
		end
	end

	coe_conv u_conv (
		.device_us (dev_s1),
		.device_ns (dev_ns),
		.too_large (too_large)
	);

	coe_update u_update (
		.cur            (state_q),
		.samples_needed (samples_needed_q),
		.req_type       (req_type_s1),
		.device_us      (dev_s1),
		.host_ns        (host_s1),
		.device_ns      (dev_ns),
		.too_large      (too_large),
		.nxt            (state_nxt),
		.res            (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= STATE_RESET;
			samples_needed_q <= SAMPLES_RESET;
		end else if (cfg_valid && cfg_ready) begin
			state_q          <= STATE_RESET;
			samples_needed_q <= cfg_data;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_nxt;
		end
	end

	assign out_valid     = out_valid_q;
	assign synced        = res_q.synced;
	assign host_equiv_ns = res_q.host_equiv_ns;
	assign convert_ok    = res_q.convert_ok;

endmodule

// ----- hw/rtl/coe_checker.sv -----
// -----------------------------------------------------------------------------
// coe_checker
// Port-level checks for the clock offset minimum estimator.
// -----------------------------------------------------------------------------
module coe_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        cfg_valid,
	input logic        cfg_ready,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [0:0]  synced,
	input logic signed [63:0] host_equiv_ns,
	input logic [0:0]  convert_ok
);

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(synced) &&
		$stable(host_equiv_ns) && $stable(convert_ok))
		else $error("result changed under stall");

	// a good conversion needs a locked offset
	a_ok_synced: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && convert_ok[0] |-> synced[0])
		else $error("convert_ok without lock");

	// failed conversions and observes report zero
	a_zero_fail: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !convert_ok[0] |-> host_equiv_ns == 64'sd0)
		else $error("nonzero host time on failed convert");

	// input side only backs up behind a stalled result
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("in_stall without a waiting result");

	// the config channel never stalls
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("config write not taken");

endmodule

bind clock_offset_min_estimator coe_checker u_coe_checker (.*);

// ----- tb/clock_offset_min_estimator_check.sv -----
// -----------------------------------------------------------------------------
// clock_offset_min_estimator_check
// Monitors the cfg, request and result channels of the offset estimator.
// Keeps its own estimator state, predicts one answer per request beat and
// compares every result beat, field by field, against the oldest prediction.
// -----------------------------------------------------------------------------
module clock_offset_min_estimator_check import coe_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [0:0]  req_type,
	input  logic [63:0] device_time_us,
	input  logic signed [63:0] host_time_ns,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [0:0]  synced,
	input  logic signed [63:0] host_equiv_ns,
	input  logic [0:0]  convert_ok,
	output int          fails,
	output int          pending,
	output int          requests_seen,
	output int          answers_seen,
	output int          synced_seen,
	output int          conversions_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic signed [63:0] S64_TOP = 64'sh7FFF_FFFF_FFFF_FFFF;

	coe_state_t  est;
	logic [15:0] samples_needed;
	coe_result_t offset_answers[$];

	function automatic coe_result_t estimate_step(coe_req_t req, logic [63:0] dev,
		logic signed [63:0] host);
		coe_result_t ans;
		logic [63:0] dev_ns;
		logic signed [63:0] cand;
		ans = '0;
		if (req == REQ_OBSERVE) begin
			if (host <= 0)
				return ans;
			if (dev > DEV_US_MAX) begin
				est = STATE_RESET;
				return ans;
			end
			dev_ns = dev * 64'd1000;
			if ((est.locked || est.sample_count != 0) && host < $signed(est.last_host_time))
				est = STATE_RESET;
			if (est.have_last_device && dev < est.last_device_time)
				est = STATE_RESET;
			if (!est.locked) begin
				cand = host - $signed(dev_ns);
				if (!est.have_candidate || cand < $signed(est.min_candidate)) begin
					est.min_candidate = cand;
					est.have_candidate = 1'b1;
				end
				if (est.sample_count != COUNT_MAX)
					est.sample_count = est.sample_count + 16'd1;
				// a setting of zero locks on the first sample, same as one
				if (est.sample_count >= samples_needed) begin
					est.locked_offset = est.min_candidate;
					est.locked = 1'b1;
				end
			end
			est.last_host_time = host;
			est.last_device_time = dev;
			est.have_last_device = 1'b1;
			ans.synced = est.locked;
			return ans;
		end
		if (!est.locked)
			return ans;
		ans.synced = 1'b1;
		if (dev > DEV_US_MAX)
			return ans;
		dev_ns = dev * 64'd1000;
		// dev_ns is never negative, so only an upward overflow is possible
		if ($signed(est.locked_offset) > 0 &&
				$signed(dev_ns) > S64_TOP - $signed(est.locked_offset))
			return ans;
		ans.host_equiv_ns = dev_ns + est.locked_offset;
		ans.convert_ok = 1'b1;
		return ans;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		coe_result_t want;
		coe_result_t got;
		if (!arst_n) begin
			est = STATE_RESET;
			samples_needed = SAMPLES_RESET;
			offset_answers.delete();
			fails = 0;
			pending = 0;
			requests_seen = 0;
			answers_seen = 0;
			synced_seen = 0;
			conversions_seen = 0;
		end else begin
			if (out_valid && !out_stall) begin
				got.synced = synced;
				got.host_equiv_ns = host_equiv_ns;
				got.convert_ok = convert_ok;
				answers_seen++;
				if (got.synced)
					synced_seen++;
				if (got.convert_ok)
					conversions_seen++;
				if (offset_answers.size() == 0) begin
					if (fails < 10)
						$display("ERROR: unexpected result synced=%0d ns=%0d ok=%0d",
							got.synced, $signed(got.host_equiv_ns), got.convert_ok);
					fails++;
				end else begin
					want = offset_answers.pop_front();
					if (got.synced != want.synced || got.host_equiv_ns != want.host_equiv_ns ||
							got.convert_ok != want.convert_ok) begin
						if (fails < 10) begin
							$display("ERROR: result %0d expected synced=%0d ns=%0d ok=%0d",
								answers_seen, want.synced, $signed(want.host_equiv_ns),
								want.convert_ok);
							$display("       got synced=%0d ns=%0d ok=%0d",
								got.synced, $signed(got.host_equiv_ns), got.convert_ok);
						end
						fails++;
					end
				end
			end
			// writes land only while idle, so no request beat shares this edge
			if (cfg_valid && cfg_ready) begin
				samples_needed = cfg_data;
				est = STATE_RESET;
			end
			if (in_valid && !in_stall) begin
				offset_answers.push_back(estimate_step(coe_req_t'(req_type), device_time_us,
					host_time_ns));
				requests_seen++;
			end
			pending = offset_answers.size();
		end
	end

endmodule

// ----- tb/clock_offset_min_estimator_test.sv -----
// -----------------------------------------------------------------------------
// clock_offset_min_estimator_test
// Stimulus and verdict for the clock offset estimator. A directed pass hits
// ignored samples, clearing events, locking and convert overflow, then random
// phases under several sample-count settings feed mostly monotonic timestamp
// tracks mixed with noise, with random idle bursts on both channels.
// -----------------------------------------------------------------------------
module clock_offset_min_estimator_test;
	timeunit 1ns;
	timeprecision 1ps;
	import coe_pkg::*;

	localparam int STALL_LIMIT = 1000;
	localparam int PHASE_ITEMS = 220;
	localparam logic [63:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] S64_MIN = 64'h8000_0000_0000_0000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [0:0]  req_type = REQ_OBSERVE;
	logic [63:0] device_time_us = '0;
	logic signed [63:0] host_time_ns = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [0:0]  synced;
	logic signed [63:0] host_equiv_ns;
	logic [0:0]  convert_ok;

	int fails;
	int pending;
	int requests_seen;
	int answers_seen;
	int synced_seen;
	int conversions_seen;
	int cfg_writes = 0;
	int idle_cycles = 0;
	int stall_left = 0;
	logic quiet = 1'b0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	clock_offset_min_estimator dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.req_type       (req_type),
		.device_time_us (device_time_us),
		.host_time_ns   (host_time_ns),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.synced         (synced),
		.host_equiv_ns  (host_equiv_ns),
		.convert_ok     (convert_ok)
	);

	clock_offset_min_estimator_check u_check (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.req_type         (req_type),
		.device_time_us   (device_time_us),
		.host_time_ns     (host_time_ns),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.synced           (synced),
		.host_equiv_ns    (host_equiv_ns),
		.convert_ok       (convert_ok),
		.fails            (fails),
		.pending          (pending),
		.requests_seen    (requests_seen),
		.answers_seen     (answers_seen),
		.synced_seen      (synced_seen),
		.conversions_seen (conversions_seen)
	);

	// result-side back-pressure in random bursts
	always @(posedge clk) begin
		if (quiet || !arst_n) begin
			out_stall <= 1'b0;
			stall_left <= 0;
		end else if (stall_left != 0) begin
			out_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 5) == 0) begin
			out_stall <= 1'b1;
			stall_left <= $urandom_range(0, 2);
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("timeout: no beat accepted for %0d cycles", STALL_LIMIT);
			$display("clock_offset_min_estimator verification failed");
			$finish;
		end
	end

	// called at a clock edge; returns at the edge where the beat is taken
	task automatic send_request(coe_req_t req, logic [63:0] dev, logic [63:0] host);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= req;
		device_time_us <= dev;
		host_time_ns <= host;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
	endtask

	task automatic set_samples_needed(logic [15:0] value);
		in_valid <= 1'b0;
		// wait for an edge first so the last request beat is already counted
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		cfg_writes++;
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	task automatic random_phase(int count);
		logic [63:0] dev_now;
		logic [63:0] base;
		logic [63:0] host_prev;
		logic [63:0] d;
		logic [63:0] h;
		int pick;
		case ($urandom_range(0, 2))
			0: begin
				dev_now = {32'd0, $urandom};
				base = {{25{$urandom_range(0, 1) == 1}}, 7'($urandom_range(0, 127)), $urandom};
				base = $signed(base) >>> 0;
			end
			1: begin
				dev_now = {32'd0, $urandom};
				base = 64'h4000_0000_0000_0000 + {32'd0, $urandom};
			end
			default: begin
				// large device times with a large negative offset
				dev_now = 64'd1 << 52 | {32'd0, $urandom};
				base = -(64'd1 << 61) + {32'd0, $urandom};
			end
		endcase
		host_prev = dev_now * 64'd1000 + base;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 55) begin
				dev_now = dev_now + $urandom_range(1, 1000);
				h = dev_now * 64'd1000 + base + $urandom_range(0, 999);
				host_prev = h;
				send_request(REQ_OBSERVE, dev_now, h);
			end else if (pick < 72) begin
				send_request(REQ_CONVERT, dev_now + $urandom_range(0, 5000), rand64());
			end else if (pick < 77) begin
				d = DEV_US_MAX + $urandom_range(0, 6) - 64'd3;
				send_request(REQ_CONVERT, d, rand64());
			end else if (pick < 82) begin
				send_request(REQ_OBSERVE, rand64(), rand64());
			end else if (pick < 87) begin
				send_request(REQ_CONVERT, rand64(), rand64());
			end else if (pick < 91) begin
				// host time steps back
				dev_now = dev_now + 1;
				send_request(REQ_OBSERVE, dev_now, host_prev - $urandom_range(1, 100000));
			end else if (pick < 95) begin
				// device time steps back
				d = dev_now - $urandom_range(1, 1000);
				host_prev = host_prev + 64'd5000;
				send_request(REQ_OBSERVE, d, host_prev);
			end else if (pick < 98) begin
				h = ($urandom_range(0, 1) == 1) ? 64'd0 : {1'b1, 63'(rand64())};
				send_request(REQ_OBSERVE, dev_now, h);
			end else begin
				d = ($urandom_range(0, 1) == 1) ? ~64'd0 : DEV_US_MAX + $urandom_range(1, 1000);
				send_request(REQ_OBSERVE, d, host_prev + 64'd1);
			end
		end
	endtask

	initial begin
		logic [15:0] settings[8];
		settings = '{16'hFFFF, 16'd2, 16'd1, 16'd0, 16'd5, 16'd10, 16'd3, 16'd7};
		settings[4] = 16'($urandom_range(3, 40));
		settings[6] = 16'($urandom_range(1, 16));
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset setting of ten samples
		send_request(REQ_CONVERT, 64'd0, 64'd0);
		send_request(REQ_OBSERVE, 64'd5, 64'd0);
		send_request(REQ_OBSERVE, 64'd5, S64_MIN);
		send_request(REQ_OBSERVE, ~64'd0, 64'd1);
		send_request(REQ_OBSERVE, DEV_US_MAX + 64'd1, S64_MAX);
		for (int i = 0; i < 10; i++)
			send_request(REQ_OBSERVE, 64'd100 + i,
				(64'd100 + i) * 64'd1000 + 64'd500 + (i % 3) * 200);
		send_request(REQ_CONVERT, 64'd200, 64'd0);

		// one sample locks; offset at the top of the range
		set_samples_needed(16'd1);
		send_request(REQ_OBSERVE, 64'd0, S64_MAX);
		send_request(REQ_CONVERT, 64'd0, 64'd0);
		send_request(REQ_CONVERT, 64'd1, 64'd0);
		send_request(REQ_CONVERT, DEV_US_MAX, 64'd0);
		send_request(REQ_CONVERT, DEV_US_MAX + 64'd1, 64'd0);
		send_request(REQ_OBSERVE, 64'd10, 64'd5);
		send_request(REQ_CONVERT, ~64'd0, 64'd0);
		send_request(REQ_CONVERT, DEV_US_MAX, 64'd0);
		send_request(REQ_OBSERVE, 64'd3, 64'd100);

		set_samples_needed(16'd0);
		send_request(REQ_OBSERVE, 64'd7, 64'd7007);
		send_request(REQ_CONVERT, 64'd7, 64'd0);

		for (int p = 0; p < 8; p++) begin
			set_samples_needed(settings[p]);
			if (p == 7)
				quiet <= 1'b1;
			random_phase(PHASE_ITEMS);
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("covered %0d requests and %0d results across %0d sample-count writes",
			requests_seen, answers_seen, cfg_writes);
		$display("results with offset locked: %0d, good conversions: %0d, mismatches: %0d",
			synced_seen, conversions_seen, fails);
		if (fails == 0 && pending == 0)
			$display("clock_offset_min_estimator verification clean");
		else
			$display("clock_offset_min_estimator verification failed");
		$finish;
	end

endmodule
